@@ hw/rtl/sea_pkg.sv @@
package sea_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int DIM_W  = 11;
  localparam int PIX_W  = 16;
  localparam int OUT_W  = 63;
  localparam int SUM_W  = 64;
  localparam int ADDR_W = 3;

  localparam logic [ADDR_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [ADDR_W-1:0] REG_STEP   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_IWT    = 3'd3;
  localparam logic [ADDR_W-1:0] REG_SWT    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SQRT,
    ST_DIV,
    ST_ACCUM,
    ST_MUL,
    ST_TOTAL,
    ST_OUT
  } sea_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sqrt_start;
    logic div_start;
    logic accum;
    logic mul_start;
    logic total;
  } sea_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic mul_done;
    logic frame_end;
  } sea_status_t;

endpackage

@@ hw/rtl/sea_if.sv @@
interface sea_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] intensity;
  logic signed [15:0] p_gradient;
  logic signed [15:0] q_gradient;
  modport source (output valid, intensity, p_gradient, q_gradient, input ready);
  modport sink (input valid, intensity, p_gradient, q_gradient, output ready);
endinterface

interface sea_res_if;
  logic        valid;
  logic        ready;
  logic [62:0] total_energy;
  logic [62:0] data_term;
  logic [62:0] integrability_term;
  logic [62:0] smoothness_term;
  modport source (output valid, total_energy, data_term, integrability_term,
                  smoothness_term, input ready);
  modport sink (input valid, total_energy, data_term, integrability_term,
                smoothness_term, output ready);
endinterface

@@ hw/rtl/sea_ctrl.sv @@
module sea_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sea_pkg::sea_cmd_t    cmd,
  input  sea_pkg::sea_status_t status
);
  import sea_pkg::*;

  sea_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result flag: set when the result registers load, cleared when the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.total) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_SQRT;
      ST_SQRT:  if (status.sqrt_done) state_next = ST_DIV;
      ST_DIV:   if (status.div_done) state_next = ST_ACCUM;
      ST_ACCUM: state_next = status.frame_end ? ST_MUL : ST_IDLE;
      ST_MUL:   if (status.mul_done) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_TOTAL;
      ST_TOTAL: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd            = '0;
    in_ready       = (state == ST_IDLE);
    cmd.load       = (state == ST_IDLE) && in_valid;
    cmd.sqrt_start = (state == ST_READ);
    cmd.div_start  = (state == ST_SQRT) && status.sqrt_done;
    cmd.accum      = (state == ST_ACCUM);
    cmd.mul_start  = (state == ST_ACCUM) && status.frame_end;
    cmd.total      = (state == ST_TOTAL);
  end
endmodule

@@ hw/rtl/sea_dp.sv @@
module sea_dp #(
  parameter int MAX_WIDTH  = sea_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sea_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = sea_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sea_pkg::sea_cmd_t     cmd,
  output sea_pkg::sea_status_t  status,
  input  logic [15:0]           intensity,
  input  logic [15:0]           p_in,
  input  logic [15:0]           q_in,
  input  logic [10:0]           frame_width,
  input  logic [10:0]           frame_height,
  input  logic [15:0]           step_size,
  input  logic [15:0]           integrability_weight,
  input  logic [15:0]           smoothness_weight,
  output logic [62:0]           total_energy,
  output logic [62:0]           data_term,
  output logic [62:0]           integrability_term,
  output logic [62:0]           smoothness_term
);
  import sea_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CNT_W   = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                           $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int S_W     = (2 * FRAC_BITS + 18 > 34) ? 2 * FRAC_BITS + 18 : 34;
  localparam int R_W     = (S_W + 1) / 2;
  localparam int SQ_IT   = R_W;
  localparam int NUM_W   = 8 + 2 * FRAC_BITS + 4;
  localparam int SH_D    = 4 * FRAC_BITS - 16;
  localparam int SH_W    = 3 * FRAC_BITS - 16;
  localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WIDTH);
  localparam logic [CNT_W-1:0] MAXH = CNT_W'(MAX_HEIGHT);
  localparam logic [NUM_W-1:0] NUMER = NUM_W'(255) << (2 * FRAC_BITS + 4);

  // Row store of the previous row.
  logic [31:0] row_mem [MAX_WIDTH];
  logic [31:0] above;
  logic [31:0] cur, left_g, above_left;
  logic [15:0] inten;
  logic [CNT_W-1:0] col, row, w_eff, h_eff;
  logic [COL_W-1:0] col_addr;
  logic [63:0] data_sum, int_sum, sm_sum;

  assign col_addr = col[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_mem[col_addr] <= {q_in, p_in};
      above <= row_mem[col_addr];
    end
  end

  always_comb begin
    w_eff = (frame_width == '0) ? CNT_W'(1) :
            ((32'(frame_width) > MAX_WIDTH) ? MAXW : CNT_W'(frame_width));
    h_eff = (frame_height == '0) ? CNT_W'(1) :
            ((32'(frame_height) > MAX_HEIGHT) ? MAXH : CNT_W'(frame_height));
  end

  // Squared gradient magnitude, pipelined ahead of the root.
  logic [S_W-1:0] s_val;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur   <= {q_in, p_in};
      inten <= intensity;
      s_val <= (S_W'(1) << (2 * FRAC_BITS))
               + S_W'($unsigned(32'($signed(p_in) * $signed(p_in))))
               + S_W'($unsigned(32'($signed(q_in) * $signed(q_in))));
    end
  end

  // Bit-serial integer square root of s << 8.
  logic [S_W+8-1:0] sq_x;
  logic [R_W+4:0]   sq_r;
  logic [S_W+9:0]   sq_rem;
  logic [$clog2(SQ_IT+6)-1:0] sq_i;
  logic sq_busy, sq_done;
  logic [S_W+9:0] sq_trial;
  assign sq_trial = {sq_rem[S_W+7:0], sq_x[S_W+7 -: 2]} - {(S_W+10-R_W-7)'(0), sq_r, 2'b01};
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_i    <= '0;
        sq_x    <= {s_val, 8'd0};
        sq_r    <= '0;
        sq_rem  <= '0;
      end else if (sq_busy) begin
        sq_x <= sq_x << 2;
        if (!sq_trial[S_W+9]) begin
          sq_rem <= sq_trial;
          sq_r   <= {sq_r[R_W+3:0], 1'b1};
        end else begin
          sq_rem <= {sq_rem[S_W+7:0], sq_x[S_W+7 -: 2]};
          sq_r   <= {sq_r[R_W+3:0], 1'b0};
        end
        if (32'(sq_i) == (S_W + 8) / 2 - 1) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
        sq_i <= sq_i + 1'b1;
      end
    end
  end

  // Restoring divider for the prediction.
  logic [NUM_W-1:0] dv_q;
  logic [NUM_W:0]   dv_rem;
  logic [R_W+4:0]   dv_d;
  logic [$clog2(NUM_W+1)-1:0] dv_i;
  logic dv_busy, dv_done;
  logic [NUM_W+1:0] dv_sh, dv_sub;
  assign dv_sh  = {dv_rem, dv_q[NUM_W-1]};
  assign dv_sub = dv_sh - (NUM_W+2)'(dv_d);
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
    end else begin
      dv_done <= 1'b0;
      if (cmd.div_start) begin
        dv_busy <= 1'b1;
        dv_i    <= '0;
        dv_q    <= NUMER;
        dv_rem  <= '0;
        dv_d    <= sq_r;
      end else if (dv_busy) begin
        if (!dv_sub[NUM_W+1]) begin
          dv_rem <= dv_sub[NUM_W:0];
          dv_q   <= {dv_q[NUM_W-2:0], 1'b1};
        end else begin
          dv_rem <= dv_sh[NUM_W:0];
          dv_q   <= {dv_q[NUM_W-2:0], 1'b0};
        end
        if (32'(dv_i) == NUM_W - 1) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
        end
        dv_i <= dv_i + 1'b1;
      end
    end
  end

  // Residual and finite-difference terms.
  logic signed [NUM_W+1:0] dres;
  logic [63:0] dsq, esq, smsq;
  logic signed [17:0] pal, qal, pa, qa, pl, ql, e, d1, d2, d3, d4;
  always_comb begin
    dres = $signed({2'b0, inten}) - $signed({2'b0, dv_q});
    dsq  = $unsigned(64'(dres) * 64'(dres));
    pal = 18'($signed(above_left[15:0]));  qal = 18'($signed(above_left[31:16]));
    pa  = 18'($signed(above[15:0]));       qa  = 18'($signed(above[31:16]));
    pl  = 18'($signed(left_g[15:0]));      ql  = 18'($signed(left_g[31:16]));
    e  = pa - pal - ql + qal;
    d1 = pl - pal; d2 = pa - pal; d3 = qa - qal; d4 = ql - qal;
    esq  = $unsigned(64'(e) * 64'(e));
    smsq = $unsigned(64'(d1) * 64'(d1)) + $unsigned(64'(d2) * 64'(d2))
         + $unsigned(64'(d3) * 64'(d3)) + $unsigned(64'(d4) * 64'(d4));
  end

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  logic col_last, row_last;
  assign col_last = !((col + 1'b1) < w_eff);
  assign row_last = !((row + 1'b1) < h_eff);
  assign status.frame_end = col_last && row_last;

  // Accumulation and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0;
      data_sum <= '0; int_sum <= '0; sm_sum <= '0;
      left_g <= '0; above_left <= '0;
    end else if (cmd.accum) begin
      if (row != '0 && col != '0) begin
        int_sum <= sat_add(int_sum, esq);
        sm_sum  <= sat_add(sm_sum, smsq);
      end
      data_sum   <= sat_add(data_sum, dsq);
      above_left <= above;
      left_g     <= cur;
      if (!col_last) begin
        col <= col + 1'b1;
      end else begin
        col <= '0;
        row <= row_last ? '0 : row + 1'b1;
      end
    end else if (cmd.total) begin
      data_sum <= '0; int_sum <= '0; sm_sum <= '0;
      left_g <= '0; above_left <= '0;
    end
  end

  // Shared 32x32 multiplier for the final weighting, one partial product a cycle.
  logic [63:0] mop_a;
  logic [31:0] mop_b;
  logic [63:0] mpp;
  logic [127:0] macc;
  logic [3:0] mi;
  logic mbusy, mdone;
  logic [31:0] st2;
  logic [63:0] t1, t2, t3;
  assign st2 = 32'(step_size) * 32'(step_size);
  assign mpp = mop_a[31:0] * mop_b;

  function automatic logic [62:0] scale(input logic [127:0] v, input int sh);
    logic [127:0] x;
    x = (sh >= 0) ? (v >> sh) : (v << (-sh));
    if (sh < 0 && (v >> (63 + sh)) != 0) return '1;
    return (x[127:63] != 0) ? '1 : x[62:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      mi    <= '0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mi    <= '0;
      end else if (mbusy) begin
        mi <= mi + 1'b1;
        unique case (mi)
          4'd0: begin mop_a <= data_sum; mop_b <= st2; macc <= '0; end
          4'd1: begin macc <= 128'(mpp); mop_a <= mop_a >> 32; end
          4'd2: begin
            t1 <= {1'b0, scale(macc + (128'(mpp) << 32), SH_D)};
            mop_a <= int_sum; mop_b <= 32'(integrability_weight);
          end
          4'd3: begin macc <= 128'(mpp); mop_a <= mop_a >> 32; end
          4'd4: begin
            t2 <= {1'b0, scale(macc + (128'(mpp) << 32), SH_W)};
            mop_a <= sm_sum; mop_b <= 32'(smoothness_weight);
          end
          4'd5: begin macc <= 128'(mpp); mop_a <= mop_a >> 32; end
          4'd6: begin
            t3 <= {1'b0, scale(macc + (128'(mpp) << 32), SH_W)};
            mbusy <= 1'b0;
            mdone <= 1'b1;
          end
          default: mbusy <= 1'b0;
        endcase
      end
    end
  end

  assign status.sqrt_done = sq_done;
  assign status.div_done  = dv_done;
  assign status.mul_done  = mdone;

  // Saturating total and output registers.
  logic [63:0] tsum;
  always_comb begin
    tsum = t1 + t2;
    if (tsum[63]) tsum = {1'b0, {63{1'b1}}};
    tsum = tsum + t3;
    if (tsum[63]) tsum = {1'b0, {63{1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.total) begin
      total_energy       <= tsum[62:0];
      data_term          <= t1[62:0];
      integrability_term <= t2[62:0];
      smoothness_term    <= t3[62:0];
    end
  end
endmodule

@@ hw/rtl/sea_regs.sv @@
module sea_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [10:0] frame_width,
  output logic [10:0] frame_height,
  output logic [15:0] step_size,
  output logic [15:0] integrability_weight,
  output logic [15:0] smoothness_weight
);
  import sea_pkg::*;

  logic [ADDR_W-1:0] idx;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd1024; frame_height <= 11'd1024;
      step_size <= 16'd256; integrability_weight <= 16'd256;
      smoothness_weight <= 16'd256;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_WIDTH:  frame_width <= pwdata[10:0];
        REG_HEIGHT: frame_height <= pwdata[10:0];
        REG_STEP:   step_size <= pwdata[15:0];
        REG_IWT:    integrability_weight <= pwdata[15:0];
        REG_SWT:    smoothness_weight <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      REG_STEP:   prdata = 32'(step_size);
      REG_IWT:    prdata = 32'(integrability_weight);
      REG_SWT:    prdata = 32'(smoothness_weight);
      default:    prdata = '0;
    endcase
  end
endmodule

@@ hw/rtl/shading_energy_accumulator.sv @@
// Shading energy accumulator.
// Pixels enter on the pix channel in raster order, one request per pixel,
// carrying intensity and the p and q gradients in Q8.8. After the last
// pixel of a frame, one request on the res channel carries the weighted
// data, integrability and smoothness terms and their total, Q47.16.
// Pixels are taken one at a time: the accept step, the row store read, the
// bit-serial square root, the restoring divider of the prediction, then the
// accumulate step. The two serial units limit how fast pixels are taken.
// The last pixel of a frame then goes through the shared 32x32 multiplier, a
// wait for a free result slot and a step that loads the result registers,
// before the next pixel is taken.
// The result is held in its registers until the receiver takes it; pixels of
// the next frame go on meanwhile, and only the next frame's end waits for it.
// Reset clears counters, sums and control; the row store needs no clearing
// since each entry is written in the first row before its value is used.
// Registers are written over the APB-style port; the user must write them
// only while the block is idle, which the block itself does not enforce.
module shading_energy_accumulator #(
  parameter int MAX_WIDTH  = sea_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sea_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = sea_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sea_pix_if.sink     pix,
  sea_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sea_pkg::*;

  sea_cmd_t    cmd;
  sea_status_t status;
  logic [10:0] frame_width, frame_height;
  logic [15:0] step_size, integrability_weight, smoothness_weight;

  sea_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .frame_width, .frame_height, .step_size, .integrability_weight,
    .smoothness_weight
  );

  sea_ctrl u_ctrl (
    .clk, .rst, .in_valid(pix.valid), .in_ready(pix.ready),
    .out_valid(res.valid), .out_ready(res.ready), .cmd, .status
  );

  sea_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .status,
    .intensity(pix.intensity), .p_in(pix.p_gradient), .q_in(pix.q_gradient),
    .frame_width, .frame_height, .step_size, .integrability_weight,
    .smoothness_weight,
    .total_energy(res.total_energy), .data_term(res.data_term),
    .integrability_term(res.integrability_term),
    .smoothness_term(res.smoothness_term)
  );
endmodule

@@ hw/rtl/sea_checker.sv @@
module sea_checker (
  input logic clk,
  input logic rst,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [62:0] res_total
);
  // A result stays offered until taken.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");

  // A taken pixel is followed by a busy cycle.
  assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !pix_ready) else $error("pixel overlap");

  // Stalled total holds.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_total)) else $error("total changed");
endmodule

bind shading_energy_accumulator sea_checker u_chk (
  .clk, .rst, .pix_valid(pix.valid), .pix_ready(pix.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_total(res.total_energy)
);

@@ tb/tb_shading_energy_accumulator.sv @@
module tb_shading_energy_accumulator;
  import sea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [62:0] total;
    logic [62:0] data;
    logic [62:0] integ;
    logic [62:0] smooth;
  } energy_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sea_pix_if pix ();
  sea_res_if res ();

  shading_energy_accumulator u_top (
    .clk(clk), .rst(rst), .pix(pix), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the configuration and of the accumulator state.
  logic [10:0] cfg_width, cfg_height;
  logic [15:0] cfg_step, cfg_iwt, cfg_swt;
  logic [31:0] row_above [MAX_WIDTH_DEF];
  logic [31:0] left_grad, above_left_grad;
  int unsigned row_cnt, col_cnt;
  logic [63:0] data_acc, integ_acc, smooth_acc;

  energy_t energy_q[$];
  int errors;
  int pixels_sent;
  int idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic report(input string what, input logic [62:0] got, input logic [62:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Weighted product, truncated and clamped to 63 bits.
  function automatic logic [63:0] weigh(input logic [63:0] a, input logic [63:0] b,
                                        input int sh);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> sh;
    return (prod > {64'd0, MAX63}) ? MAX63 : prod[63:0];
  endfunction

  function automatic longint sext(input logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // Update the shadow state with one accepted pixel; queue the frame energies at its end.
  task automatic accumulate_pixel(input logic [15:0] inten, input logic [15:0] pg,
                                  input logic [15:0] qg);
    int unsigned w, h, col;
    logic [31:0] cur, above;
    longint p, q, d, e, d1, d2, d3, d4, pal, qal, pa, qa, pl, ql;
    logic [63:0] s, r, pred, t1, t2, t3, tot;
    energy_t res_e;
    w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : cfg_width);
    h = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : cfg_height);
    cur = {qg, pg};
    p = sext(pg);
    q = sext(qg);
    col = col_cnt % MAX_WIDTH_DEF;
    above = row_above[col];
    // Lambertian prediction and the shading residual.
    s = 64'd65536 + 64'(p * p) + 64'(q * q);
    r = int_sqrt(s << 8);
    pred = (64'd255 << 20) / r;
    d = longint'({48'd0, inten}) - longint'(pred);
    data_acc = sat_add(data_acc, 64'(d * d));
    // Finite differences around the pixel above and to the left.
    if (row_cnt >= 1 && col_cnt >= 1) begin
      pal = sext(above_left_grad[15:0]);
      qal = sext(above_left_grad[31:16]);
      pa = sext(above[15:0]);
      qa = sext(above[31:16]);
      pl = sext(left_grad[15:0]);
      ql = sext(left_grad[31:16]);
      e = pa - pal - ql + qal;
      d1 = pl - pal;
      d2 = pa - pal;
      d3 = qa - qal;
      d4 = ql - qal;
      integ_acc = sat_add(integ_acc, 64'(e * e));
      smooth_acc = sat_add(smooth_acc,
                           64'(d1 * d1) + 64'(d2 * d2) + 64'(d3 * d3) + 64'(d4 * d4));
    end
    above_left_grad = above;
    left_grad = cur;
    row_above[col] = cur;
    if (col_cnt + 1 < w) begin
      col_cnt++;
      return;
    end
    col_cnt = 0;
    if (row_cnt + 1 < h) begin
      row_cnt++;
      return;
    end
    row_cnt = 0;
    // Frame end: weight the sums and form the saturating total.
    t1 = weigh(data_acc, 64'(cfg_step) * 64'(cfg_step), 16);
    t2 = weigh(integ_acc, 64'(cfg_iwt), 8);
    t3 = weigh(smooth_acc, 64'(cfg_swt), 8);
    tot = t1 + t2;
    if (tot > MAX63) tot = MAX63;
    tot = tot + t3;
    if (tot > MAX63) tot = MAX63;
    res_e.total = tot[62:0];
    res_e.data = t1[62:0];
    res_e.integ = t2[62:0];
    res_e.smooth = t3[62:0];
    energy_q.push_back(res_e);
    data_acc = 0;
    integ_acc = 0;
    smooth_acc = 0;
    left_grad = 0;
    above_left_grad = 0;
  endtask

  // Offer one pixel request, with random idle cycles ahead of it.
  task automatic send_pixel(input logic [15:0] inten, input logic [15:0] pg,
                            input logic [15:0] qg);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.intensity <= inten;
    pix.p_gradient <= pg;
    pix.q_gradient <= qg;
    do @(posedge clk); while (!pix.ready);
    accumulate_pixel(inten, pg, qg);
    pixels_sent++;
  endtask

  // Drop valid, drain all energies and give the block time to go idle.
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (energy_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH: cfg_width = value[10:0];
      REG_HEIGHT: cfg_height = value[10:0];
      REG_STEP: cfg_step = value[15:0];
      REG_IWT: cfg_iwt = value[15:0];
      REG_SWT: cfg_swt = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int n);
    repeat (n) send_pixel(pick16(), pick16(), pick16());
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each accepted energy request with the oldest prediction.
  always @(posedge clk) begin
    energy_t want;
    if (!rst && res.valid && res.ready) begin
      if (energy_q.size() == 0) begin
        report("unexpected result", res.total_energy, '0);
      end else begin
        want = energy_q.pop_front();
        if (res.total_energy !== want.total) report("total_energy", res.total_energy, want.total);
        if (res.data_term !== want.data) report("data_term", res.data_term, want.data);
        if (res.integrability_term !== want.integ)
          report("integrability_term", res.integrability_term, want.integ);
        if (res.smoothness_term !== want.smooth)
          report("smoothness_term", res.smoothness_term, want.smooth);
      end
    end
  end

  // Single-pixel frames with extreme fields, with zero and then unit dimensions.
  task automatic test_extremes();
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_pixel(16'hFFFF, 16'h8000, 16'h8000);
    send_pixel(16'h0000, 16'h8000, 16'h7FFF);
    send_pixel(16'hFF00, 16'h0000, 16'h0000);
    settle();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_STEP, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h8000, 16'h8000);
    send_pixel(16'h1234, 16'h0100, 16'hFF00);
    settle();
  endtask

  // A 3x3 grid with opposing gradients and heavy weights, then a random 3x3 frame with the weights at zero.
  task automatic test_small_grid();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_STEP, 0);
    write_reg(REG_IWT, 16'hFFFF);
    write_reg(REG_SWT, 16'hFFFF);
    for (int i = 0; i < 9; i++) begin
      send_pixel(i[0] ? 16'hFFFF : 16'h0000, i[0] ? 16'h7FFF : 16'h8000,
                 i[1] ? 16'h8000 : 16'h7FFF);
    end
    settle();
    write_reg(REG_IWT, 0);
    write_reg(REG_SWT, 0);
    write_reg(REG_STEP, 256);
    send_frame(9);
    settle();
  endtask

  // Dimensions shrunk mid-frame end the frame at the current pixel.
  task automatic test_shrink_midframe();
    write_reg(REG_IWT, 256);
    write_reg(REG_SWT, 256);
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 2047);
    send_frame(5);
    settle();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 2);
    send_frame(1);
    settle();
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 2);
    send_frame(8);
    settle();
  endtask

  // Width beyond the maximum is clamped to a full row.
  task automatic test_wide_row();
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_HEIGHT, 1);
    send_frame(MAX_WIDTH_DEF);
    settle();
  endtask

  // The receiver holds off while frames keep arriving, so the input stalls.
  task automatic test_backpressure();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 1);
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 600;
    send_frame(12);
    settle();
  endtask

  // Random frames under changing configurations, idle and stall phases.
  task automatic test_random();
    int start, phase, w, h;
    start = pixels_sent;
    phase = 0;
    while (pixels_sent - start < 160) begin
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 81; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 81; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      w = ($urandom_range(15) == 0) ? $urandom_range(40, 16) : $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_STEP, pick16());
      write_reg(REG_IWT, pick16());
      write_reg(REG_SWT, pick16());
      repeat ($urandom_range(4, 1)) send_frame(w * h);
      settle();
      phase++;
    end
  endtask

  initial begin
    errors = 0;
    pixels_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    cfg_width = 1024;
    cfg_height = 1024;
    cfg_step = 256;
    cfg_iwt = 256;
    cfg_swt = 256;
    foreach (row_above[i]) row_above[i] = '0;
    left_grad = 0;
    above_left_grad = 0;
    row_cnt = 0;
    col_cnt = 0;
    data_acc = 0;
    integ_acc = 0;
    smooth_acc = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix.valid <= 1'b0;
    pix.intensity <= '0;
    pix.p_gradient <= '0;
    pix.q_gradient <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_small_grid();
    test_shrink_midframe();
    idle_pct = 81;
    test_wide_row();
    test_backpressure();
    test_random();

    settle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ shading_energy_accumulator.f @@
hw/rtl/sea_pkg.sv
hw/rtl/sea_if.sv
hw/rtl/sea_ctrl.sv
hw/rtl/sea_dp.sv
hw/rtl/sea_regs.sv
hw/rtl/shading_energy_accumulator.sv
hw/rtl/sea_checker.sv
tb/tb_shading_energy_accumulator.sv
